[rtl/alps_pkg.sv]
// Shared constants and codes of the arc-length polyline sampler.
package alps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 9;
  localparam int COORD_W = 32;
  localparam int T_W     = 17;
  localparam int LEN_W   = 48;
  localparam int TGT_W   = 64;
  localparam int LT_W    = 17;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int RAD_W   = 68;
  localparam int ROOT_W  = RAD_W / 2;

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 2'd0,
    CMD_FINALIZE = 2'd1,
    CMD_EVALUATE = 2'd2
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_REJECT    = 2'd1,
    ST_ZERO_LEN  = 2'd2,
    ST_NOT_FINAL = 2'd3
  } status_e;

endpackage

[rtl/alps_in_if.sv]
// Input channel of the sampler: one command word with its point and parameter.
interface alps_in_if import alps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [COORD_W-1:0] point_z;
  logic [T_W-1:0]     position_t;

  modport source (output valid, command, point_x, point_y, point_z, position_t,
                  input ready);
  modport sink (input valid, command, point_x, point_y, point_z, position_t,
                output ready);
endinterface

[rtl/alps_out_if.sv]
// Result channel of the sampler: status, evaluated point and total length.
interface alps_out_if import alps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [COORD_W-1:0] out_z;
  logic [LEN_W-1:0]   total_length;

  modport source (output valid, status, out_x, out_y, out_z, total_length,
                  input ready);
  modport sink (input valid, status, out_x, out_y, out_z, total_length,
                output ready);
endinterface

[rtl/alps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module alps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/alps_mul.sv]
// Shared signed multiplier with a registered product.
module alps_mul import alps_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);
  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end
endmodule

[rtl/alps_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
module alps_isqrt import alps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);
  localparam int CW = $clog2(ROOT_W + 1);
  localparam int RW = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_q;
  logic [RW-1:0]     rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [RW-1:0]     shifted;
  logic [RW-1:0]     trial;
  logic              fits;

  assign shifted = {rem_q[RW-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign fits    = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? shifted - trial : shifted;
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

[rtl/alps_div.sv]
// Iterative restoring divider for the local parameter, one quotient bit per cycle.
module alps_div import alps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TGT_W-1:0] num_i,
  input  logic [LEN_W-1:0] den_i,
  output logic             done_o,
  output logic [LT_W-1:0]  quot_o
);
  localparam int CW = $clog2(LT_W + 1);

  logic [TGT_W-1:0] rem_q;
  logic [TGT_W-1:0] dsh_q;
  logic [LT_W-1:0]  quot_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             fits;

  assign fits = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(LT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The numerator never exceeds the span times one in Q1.16, so the
  // quotient fits in LT_W bits starting from the divisor shifted by LT_W-1.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= TGT_W'({den_i, {(LT_W-1){1'b0}}});
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? rem_q - dsh_q : rem_q;
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[LT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

[rtl/arc_length_polyline_sampler.sv]
// Top level of the arc-length polyline sampler: sequencer, stores and shared units.
//
// Usage: the input channel takes one word per command (append a point,
// finalize the curve, evaluate at t); every word yields exactly one word on
// the result channel. The configuration port sets the expected point count
// and clears the stored curve; write it only while the block is idle.
// The block works on one word at a time and drops ready while it does.
// Finalize reads each segment from the store, squares the three differences
// on the shared multiplier and takes a square root. Evaluate scales the
// 48-bit length in two passes on the multiplier, runs a binary search with
// one store read per step, waits for the divider and does a multiply per
// coordinate.
// A finished result sits in the output register; the block may take the
// next word meanwhile and holds its next result until the register frees.
// After reset the count is 2, the curve is empty and unfinalized; the point
// stores hold no defined data until written and need no clearing pass.
module arc_length_polyline_sampler import alps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  alps_in_if.sink          in_i,
  alps_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_FIN_RD0, S_FIN_P0, S_FIN_RD, S_FIN_DIFF, S_FIN_MUL, S_FIN_ACC,
    S_FIN_SQRT, S_FIN_END, S_EV_MUL0, S_EV_MUL1, S_EV_MUL2, S_EV_BS, S_EV_BSW,
    S_EV_SEL, S_EV_PT, S_EV_RDB, S_EV_SPAN, S_EV_DIV, S_EV_LMUL, S_EV_LACC,
    S_DONE
  } state_e;

  function automatic logic [COORD_W:0] abs_diff(logic [COORD_W-1:0] b,
                                                logic [COORD_W-1:0] a);
    logic signed [COORD_W:0] d;
    d = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
    return d[COORD_W] ? -d : d;
  endfunction

  state_e state_q, state_d;
  logic [CNT_W-1:0]   pc_q, pc_d, fill_q, fill_d;
  logic               fin_q, fin_d;
  logic [LEN_W-1:0]   len_q, len_d, tot_q, tot_d, cuma_q, cuma_d;
  logic [T_W-1:0]     t_q, t_d;
  logic [CNT_W-1:0]   idx_q, idx_d, hi_q, hi_d, mid_q, mid_d;
  logic [1:0]         axis_q, axis_d;
  logic [COORD_W-1:0] pa_q [3];
  logic [COORD_W-1:0] pa_d [3];
  logic [COORD_W-1:0] pb_q [3];
  logic [COORD_W-1:0] pb_d [3];
  logic [COORD_W-1:0] r_q [3];
  logic [COORD_W-1:0] r_d [3];
  logic [COORD_W:0]   mag_q [3];
  logic [COORD_W:0]   mag_d [3];
  logic [RAD_W-1:0]   acc_q, acc_d;
  logic [TGT_W-1:0]   tgt_q, tgt_d;
  logic [LT_W-1:0]    lt_q, lt_d;
  logic [ST_W-1:0]    st_q, st_d;
  logic               oval_q, oval_d;
  logic [ST_W-1:0]    ost_q, ost_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [LEN_W-1:0]   olen_q, olen_d;

  logic               accept;
  logic [31:0]        cfg_ext;
  logic [CNT_W-1:0]   cfg_cnt;
  logic [AW-1:0]      raddr;
  logic               pt_we, cum_we;
  logic [AW-1:0]      cum_waddr;
  logic [LEN_W-1:0]   cum_wdata;
  logic [COORD_W-1:0] in_pt [3];
  logic [COORD_W-1:0] rd_pt [3];
  logic [LEN_W-1:0]   rd_cum;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic               sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]  root;
  logic               div_start, div_done;
  logic [LT_W-1:0]    quot;
  logic [TGT_W-1:0]   div_num;
  logic [LEN_W-1:0]   span;
  logic [CNT_W:0]     mid_sum;
  logic [COORD_W:0]   ldiff;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_pt[0] = in_i.point_x;
  assign in_pt[1] = in_i.point_y;
  assign in_pt[2] = in_i.point_z;

  assign cfg_ext = 32'(cfg_wdata_i);
  assign cfg_cnt = (cfg_ext < 32'd2) ? CNT_W'(2) :
                   (cfg_ext > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) :
                   CNT_W'(cfg_ext);

  assign span    = rd_cum - cuma_q;
  assign div_num = tgt_q - {cuma_q, 16'b0};
  assign mid_sum = {1'b0, idx_q} + {1'b0, hi_q};
  assign ldiff   = $signed({pb_q[axis_q][COORD_W-1], pb_q[axis_q]})
                 - $signed({pa_q[axis_q][COORD_W-1], pa_q[axis_q]});

  for (genvar k = 0; k < 3; k++) begin : g_pt
    alps_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clk_i   (clk_i),
      .we_i    (pt_we),
      .waddr_i (fill_q[AW-1:0]),
      .wdata_i (in_pt[k]),
      .raddr_i (raddr),
      .rdata_o (rd_pt[k])
    );
  end

  alps_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS)) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (cum_we),
    .waddr_i (cum_waddr),
    .wdata_i (cum_wdata),
    .raddr_i (raddr),
    .rdata_o (rd_cum)
  );

  alps_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  alps_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_q + RAD_W'(prod)),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  alps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (span),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    fill_d  = fill_q;
    fin_d   = fin_q;
    len_d   = len_q;
    tot_d   = tot_q;
    cuma_d  = cuma_q;
    t_d     = t_q;
    idx_d   = idx_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    axis_d  = axis_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    r_d     = r_q;
    mag_d   = mag_q;
    acc_d   = acc_q;
    tgt_d   = tgt_q;
    lt_d    = lt_q;
    st_d    = st_q;
    oval_d  = oval_q;
    ost_d   = ost_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oz_d    = oz_q;
    olen_d  = olen_q;
    raddr      = '0;
    pt_we      = 1'b0;
    cum_we     = 1'b0;
    cum_waddr  = idx_q[AW-1:0];
    cum_wdata  = '0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;

    if (oval_q && out_o.ready) begin
      oval_d = 1'b0;
    end

    if (cfg_we_i) begin
      pc_d   = cfg_cnt;
      fill_d = '0;
      fin_d  = 1'b0;
      len_d  = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          r_d     = '{default: '0};
          st_d    = ST_REJECT;
          state_d = S_DONE;
          case (in_i.command)
            CMD_APPEND: begin
              if (!fin_q && fill_q < pc_q) begin
                pt_we  = 1'b1;
                fill_d = fill_q + 1'b1;
                st_d   = ST_OK;
              end
            end
            CMD_FINALIZE: begin
              if (!fin_q && fill_q == pc_q) begin
                state_d = S_FIN_RD0;
              end
            end
            CMD_EVALUATE: begin
              if (!fin_q) begin
                st_d = ST_NOT_FINAL;
              end else begin
                t_d     = (in_i.position_t > T_ONE) ? T_ONE : in_i.position_t;
                state_d = S_EV_MUL0;
              end
            end
            default: ;
          endcase
        end
      end

      S_FIN_RD0: begin
        raddr     = '0;
        cum_we    = 1'b1;
        cum_waddr = '0;
        tot_d     = '0;
        idx_d     = CNT_W'(1);
        state_d   = S_FIN_P0;
      end

      S_FIN_P0: begin
        pa_d    = rd_pt;
        raddr   = idx_q[AW-1:0];
        state_d = S_FIN_DIFF;
      end

      S_FIN_RD: begin
        raddr   = idx_q[AW-1:0];
        state_d = S_FIN_DIFF;
      end

      S_FIN_DIFF: begin
        pb_d = rd_pt;
        for (int k = 0; k < 3; k++) begin
          mag_d[k] = abs_diff(rd_pt[k], pa_q[k]);
        end
        acc_d   = '0;
        axis_d  = '0;
        state_d = S_FIN_MUL;
      end

      S_FIN_MUL: begin
        mul_a   = {1'b0, mag_q[axis_q]};
        mul_b   = {1'b0, mag_q[axis_q]};
        state_d = S_FIN_ACC;
      end

      S_FIN_ACC: begin
        acc_d  = acc_q + RAD_W'(prod);
        axis_d = axis_q + 1'b1;
        if (axis_q == 2'd2) begin
          sqrt_start = 1'b1;
          state_d    = S_FIN_SQRT;
        end else begin
          state_d = S_FIN_MUL;
        end
      end

      S_FIN_SQRT: begin
        if (sqrt_done) begin
          tot_d     = tot_q + LEN_W'(root);
          cum_we    = 1'b1;
          cum_wdata = tot_q + LEN_W'(root);
          pa_d      = pb_q;
          idx_d     = idx_q + 1'b1;
          state_d   = (idx_q + 1'b1 < fill_q) ? S_FIN_RD : S_FIN_END;
        end
      end

      S_FIN_END: begin
        if (tot_q == '0) begin
          st_d = ST_ZERO_LEN;
        end else begin
          len_d = tot_q;
          fin_d = 1'b1;
          st_d  = ST_OK;
        end
        state_d = S_DONE;
      end

      // The 48-bit length is scaled in two passes: low 32 bits, then high 16.
      S_EV_MUL0: begin
        mul_a   = MUL_W'(t_q);
        mul_b   = MUL_W'(len_q[31:0]);
        state_d = S_EV_MUL1;
      end

      S_EV_MUL1: begin
        tgt_d   = prod[TGT_W-1:0];
        mul_a   = MUL_W'(t_q);
        mul_b   = MUL_W'(len_q[LEN_W-1:32]);
        state_d = S_EV_MUL2;
      end

      S_EV_MUL2: begin
        tgt_d   = tgt_q + {prod[31:0], 32'b0};
        idx_d   = '0;
        hi_d    = fill_q;
        state_d = S_EV_BS;
      end

      S_EV_BS: begin
        if (idx_q < hi_q) begin
          mid_d   = mid_sum[CNT_W:1];
          raddr   = mid_sum[AW:1];
          state_d = S_EV_BSW;
        end else begin
          state_d = S_EV_SEL;
        end
      end

      S_EV_BSW: begin
        if ({rd_cum, 16'b0} < tgt_q) begin
          idx_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_EV_BS;
      end

      S_EV_SEL: begin
        if (idx_q == '0) begin
          raddr   = '0;
          state_d = S_EV_PT;
        end else if (idx_q >= fill_q) begin
          raddr   = AW'(fill_q - 1'b1);
          state_d = S_EV_PT;
        end else begin
          raddr   = AW'(idx_q - 1'b1);
          state_d = S_EV_RDB;
        end
      end

      S_EV_PT: begin
        r_d     = rd_pt;
        st_d    = ST_OK;
        state_d = S_DONE;
      end

      S_EV_RDB: begin
        pa_d    = rd_pt;
        cuma_d  = rd_cum;
        raddr   = idx_q[AW-1:0];
        state_d = S_EV_SPAN;
      end

      S_EV_SPAN: begin
        pb_d   = rd_pt;
        axis_d = '0;
        if (span == '0) begin
          lt_d    = '0;
          state_d = S_EV_LMUL;
        end else begin
          div_start = 1'b1;
          state_d   = S_EV_DIV;
        end
      end

      S_EV_DIV: begin
        if (div_done) begin
          lt_d    = quot;
          state_d = S_EV_LMUL;
        end
      end

      S_EV_LMUL: begin
        mul_a   = {ldiff[COORD_W], ldiff};
        mul_b   = MUL_W'(lt_q);
        state_d = S_EV_LACC;
      end

      // Arithmetic shift of the product by 16 gives the floored quotient.
      S_EV_LACC: begin
        r_d[axis_q] = pa_q[axis_q] + prod[COORD_W+15:16];
        axis_d      = axis_q + 1'b1;
        if (axis_q == 2'd2) begin
          st_d    = ST_OK;
          state_d = S_DONE;
        end else begin
          state_d = S_EV_LMUL;
        end
      end

      S_DONE: begin
        if (!oval_q || out_o.ready) begin
          oval_d  = 1'b1;
          ost_d   = st_q;
          ox_d    = r_q[0];
          oy_d    = r_q[1];
          oz_d    = r_q[2];
          olen_d  = len_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= CNT_W'(2);
      fill_q  <= '0;
      fin_q   <= 1'b0;
      len_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      fill_q  <= fill_d;
      fin_q   <= fin_d;
      len_q   <= len_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q  <= tot_d;
    cuma_q <= cuma_d;
    t_q    <= t_d;
    idx_q  <= idx_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    axis_q <= axis_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    r_q    <= r_d;
    mag_q  <= mag_d;
    acc_q  <= acc_d;
    tgt_q  <= tgt_d;
    lt_q   <= lt_d;
    st_q   <= st_d;
    ost_q  <= ost_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oz_q   <= oz_d;
    olen_q <= olen_d;
  end

  assign out_o.valid        = oval_q;
  assign out_o.status       = ost_q;
  assign out_o.out_x        = ox_q;
  assign out_o.out_y        = oy_q;
  assign out_o.out_z        = oz_q;
  assign out_o.total_length = olen_q;

`ifndef SYNTHESIS
  a_fin_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> fill_q == pc_q)
    else $error("finalized curve without a full store");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= pc_q)
    else $error("fill count beyond point count");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> fill_q == '0 && !fin_q && len_q == '0)
    else $error("count write did not clear the curve");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(oval_q) |-> $past(state_q == S_DONE))
    else $error("result word appeared outside the done step");
`endif
endmodule

[tb/testbench.sv]
// Self-checking testbench for the arc-length polyline sampler.
module testbench;
  import alps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int ITEM_GOAL = 900;

  typedef struct {
    status_e            status;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [LEN_W-1:0]   total;
  } sample_t;

  // Holds the expected result words in order and compares arrivals.
  class sample_scoreboard;
    sample_t pending[$];
    int      errors;
    int      checked;

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function void note_input(sample_t exp);
      pending.push_back(exp);
    endfunction

    function void check_result(sample_t got);
      sample_t exp;
      if (pending.size() == 0) begin
        report("result word with no expectation waiting");
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.status != exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.x != exp.x) report($sformatf("out_x %h, expected %h", got.x, exp.x));
      if (got.y != exp.y) report($sformatf("out_y %h, expected %h", got.y, exp.y));
      if (got.z != exp.z) report($sformatf("out_z %h, expected %h", got.z, exp.z));
      if (got.total != exp.total)
        report($sformatf("total_length %h, expected %h", got.total, exp.total));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  alps_in_if  in_ch ();
  alps_out_if out_ch ();

  arc_length_polyline_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  sample_scoreboard sb = new();

  // Shadow copy of the curve store.
  int                       curve_count;
  logic signed [COORD_W-1:0] xs [MAX_POINTS];
  logic signed [COORD_W-1:0] ys [MAX_POINTS];
  logic signed [COORD_W-1:0] zs [MAX_POINTS];
  logic [LEN_W-1:0]          cum [MAX_POINTS];
  int                        fill;
  bit                        is_final;
  logic [LEN_W-1:0]          length_sum;

  int sent;
  int curves_built;
  int configs_written;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void apply_count(logic [CFG_W-1:0] v);
    int c;
    c = v;
    if (c < 2) c = 2;
    if (c > MAX_POINTS) c = MAX_POINTS;
    curve_count = c;
    fill = 0;
    is_final = 0;
    length_sum = '0;
  endfunction

  // floor(sqrt(dx^2 + dy^2 + dz^2)) on raw Q16.16 differences.
  function automatic logic [ROOT_W-1:0] segment_root(int i);
    logic [RAD_W-1:0]  rad;
    logic [RAD_W-1:0]  m;
    logic [RAD_W-1:0]  c68;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] c;
    longint            d;
    rad = '0;
    d = longint'(xs[i]) - longint'(xs[i-1]);
    m = (d < 0) ? RAD_W'(-d) : RAD_W'(d);
    rad += m * m;
    d = longint'(ys[i]) - longint'(ys[i-1]);
    m = (d < 0) ? RAD_W'(-d) : RAD_W'(d);
    rad += m * m;
    d = longint'(zs[i]) - longint'(zs[i-1]);
    m = (d < 0) ? RAD_W'(-d) : RAD_W'(d);
    rad += m * m;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      c = root | (ROOT_W'(1) << b);
      c68 = RAD_W'(c);
      if (c68 * c68 <= rad) root = c;
    end
    return root;
  endfunction

  function automatic logic [COORD_W-1:0] blend(logic signed [COORD_W-1:0] a,
                                               logic signed [COORD_W-1:0] b,
                                               longint lt);
    longint p;
    p = (longint'(b) - longint'(a)) * lt;
    // Arithmetic shift rounds toward minus infinity, as the interpolation needs.
    return COORD_W'(longint'(a) + (p >>> 16));
  endfunction

  function automatic sample_t predict_sample(logic [CMD_W-1:0] cmd,
                                             logic [COORD_W-1:0] px,
                                             logic [COORD_W-1:0] py,
                                             logic [COORD_W-1:0] pz,
                                             logic [T_W-1:0] pt);
    sample_t     r;
    longint unsigned total;
    longint unsigned t;
    longint unsigned target;
    longint unsigned lower;
    longint unsigned span;
    longint      lt;
    int          lo;
    int          hi;
    int          mid;
    r.status = ST_REJECT;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    case (cmd)
      CMD_APPEND: begin
        if (!is_final && fill < curve_count) begin
          xs[fill] = px;
          ys[fill] = py;
          zs[fill] = pz;
          fill++;
          r.status = ST_OK;
        end
      end
      CMD_FINALIZE: begin
        if (!is_final && fill == curve_count) begin
          total = 0;
          cum[0] = '0;
          for (int i = 1; i < fill; i++) begin
            total += segment_root(i);
            cum[i] = LEN_W'(total);
          end
          if (total == 0) begin
            r.status = ST_ZERO_LEN;
          end else begin
            length_sum = LEN_W'(total);
            is_final = 1;
            r.status = ST_OK;
          end
        end
      end
      CMD_EVALUATE: begin
        if (!is_final) begin
          r.status = ST_NOT_FINAL;
        end else begin
          t = pt;
          if (t > 65536) t = 65536;
          target = t * length_sum;
          lo = 0;
          hi = fill;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if ((longint'(cum[mid]) << 16) < target) lo = mid + 1;
            else hi = mid;
          end
          if (lo == 0) begin
            r.x = xs[0]; r.y = ys[0]; r.z = zs[0];
          end else if (lo >= fill) begin
            r.x = xs[fill-1]; r.y = ys[fill-1]; r.z = zs[fill-1];
          end else begin
            lower = cum[lo-1];
            span = cum[lo] - lower;
            lt = 0;
            if (span > 0) begin
              lt = (target - (lower << 16)) / span;
              if (lt > 65536) lt = 65536;
            end
            r.x = blend(xs[lo-1], xs[lo], lt);
            r.y = blend(ys[lo-1], ys[lo], lt);
            r.z = blend(zs[lo-1], zs[lo], lt);
          end
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.total = length_sum;
    return r;
  endfunction

  // Sends one word; valid stays high into the next word unless a gap is taken.
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] px,
                           logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz,
                           logic [T_W-1:0] pt);
    int gap_pct;
    gap_pct = (sent < ITEM_GOAL / 3) ? 29 : (sent < 2 * ITEM_GOAL / 3) ? 68 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.point_x    <= px;
    in_ch.point_y    <= py;
    in_ch.point_z    <= pz;
    in_ch.position_t <= pt;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(predict_sample(cmd, px, py, pz, pt));
    sent++;
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_count(v);
    configs_written++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return COORD_W'($urandom_range(20 << 16)) - COORD_W'(10 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [T_W-1:0] pick_t();
    case ($urandom_range(7))
      0: return '0;
      1: return T_ONE;
      2: return T_W'($urandom_range(131071, 65537));
      default: return T_W'($urandom_range(65536));
    endcase
  endfunction

  task automatic send_eval(logic [T_W-1:0] pt);
    send_word(CMD_EVALUATE, $urandom, $urandom, $urandom, pt);
  endtask

  task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            logic [COORD_W-1:0] pz);
    send_word(CMD_APPEND, px, py, pz, T_W'($urandom));
  endtask

  task automatic send_finalize();
    send_word(CMD_FINALIZE, $urandom, $urandom, $urandom, T_W'($urandom));
  endtask

  // One curve with random content; flat curves and repeated points now and then.
  task automatic run_curve(logic [CFG_W-1:0] cfg_val);
    bit                 flat;
    logic [COORD_W-1:0] px, py, pz;
    write_count(cfg_val);
    flat = ($urandom_range(5) == 0);
    if ($urandom_range(3) == 0) send_eval(pick_t());
    px = pick_coord(); py = pick_coord(); pz = pick_coord();
    for (int i = 0; i < curve_count; i++) begin
      if (i == curve_count / 2 && $urandom_range(4) == 0) send_finalize();
      if (!flat && $urandom_range(4) != 0) begin
        px = pick_coord(); py = pick_coord(); pz = pick_coord();
      end
      send_point(px, py, pz);
    end
    if ($urandom_range(4) == 0) send_point(pick_coord(), pick_coord(), pick_coord());
    send_finalize();
    if ($urandom_range(2) == 0) send_finalize();
    repeat ($urandom_range(10, 4)) send_eval(pick_t());
    if ($urandom_range(5) == 0)
      send_word(CMD_UNKNOWN, $urandom, $urandom, $urandom, T_W'($urandom));
    curves_built++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int stall_pct;
    sample_t got;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_pct = (sent < ITEM_GOAL / 3) ? 68 : (sent < 2 * ITEM_GOAL / 3) ? 29 : 0;
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_e'(out_ch.status);
        got.x      = out_ch.out_x;
        got.y      = out_ch.out_y;
        got.z      = out_ch.out_z;
        got.total  = out_ch.total_length;
        sb.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #(20 * 1500000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int big_left;
    int r;
    logic [CFG_W-1:0] v;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_APPEND;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.position_t = '0;
    sent = 0;
    apply_count(CFG_W'(2));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on the reset count of two points.
    send_eval(T_ONE);
    send_finalize();
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point('0, '0, '0);
    send_finalize();
    send_finalize();
    send_eval('0);
    send_eval(T_ONE);
    send_eval(T_W'(32768));
    send_eval(T_W'(131071));
    send_eval(T_W'(1));
    send_word(CMD_UNKNOWN, '1, '1, '1, '1);
    // A curve of coincident points has no length.
    write_count(CFG_W'(0));
    send_point(32'h0001_0000, 32'hffff_0000, '0);
    send_point(32'h0001_0000, 32'hffff_0000, '0);
    send_finalize();
    send_eval(T_W'(100));
    send_finalize();

    big_left = 3;
    while (sent < ITEM_GOAL) begin
      r = $urandom_range(19);
      if (r == 0 && big_left > 0) begin
        big_left--;
        v = ($urandom_range(1) == 0) ? CFG_W'(MAX_POINTS) : CFG_W'($urandom_range(511, 257));
      end else if (r == 1) begin
        v = CFG_W'($urandom_range(1));
      end else begin
        v = CFG_W'($urandom_range(9, 2));
      end
      run_curve(v);
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d words sent over %0d curves and %0d count writes, %0d results checked",
             sent, curves_built, configs_written, sb.checked);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
